/* hdl/obst_pkg.sv */
// ----------------------------------------------------------------------------
// obst_pkg
// Shared types and constants for the ordered byte set table.
// ----------------------------------------------------------------------------
`default_nettype none

package obst_pkg;

  // Entry store geometry
  localparam int OBST_DEPTH    = 256;
  localparam int OBST_ADDR_W   = $clog2(OBST_DEPTH);
  localparam int OBST_DATA_W   = 8;
  localparam int OBST_CNT_W    = OBST_ADDR_W + 1;
  localparam int OBST_CAPACITY = 256;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_SHIFT,
    S_RWAIT,
    S_FINISH
  } seq_state_t;

  // Input item
  typedef struct packed {
    req_t                   req_type;
    logic [OBST_DATA_W-1:0] element;
    logic [OBST_ADDR_W-1:0] position;
  } obst_in_t;

  // Result item
  typedef struct packed {
    status_t                status;
    logic [OBST_CNT_W-1:0]  entry_count;
    logic [OBST_DATA_W-1:0] read_value;
    logic                   was_present;
  } obst_out_t;

  // Store access request from the sequencer
  typedef struct packed {
    logic                   rd_en;
    logic [OBST_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [OBST_ADDR_W-1:0] wr_addr;
    logic [OBST_DATA_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

/* hdl/obst_store.sv */
// ----------------------------------------------------------------------------
// obst_store
// Entry memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_store (
  input  wire logic                            clk,
  input  wire obst_pkg::mem_req_t              mem_req,
  output logic [obst_pkg::OBST_DATA_W-1:0]     rd_data
);
  import obst_pkg::*;

  logic [OBST_DATA_W-1:0] mem [OBST_DEPTH];
  logic [OBST_DATA_W-1:0] rd_data_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/obst_ctrl.sv */
// ----------------------------------------------------------------------------
// obst_ctrl
// Sequencer: scans the store through one byte comparator, appends, compacts
// on delete and reads by position; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module obst_ctrl #(
  parameter int CAPACITY = obst_pkg::OBST_CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire obst_pkg::obst_in_t           in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output obst_pkg::obst_out_t               out_item,
  output obst_pkg::mem_req_t                mem_req,
  input  wire logic [obst_pkg::OBST_DATA_W-1:0] rd_data
);
  import obst_pkg::*;

  localparam logic [OBST_CNT_W-1:0] CAP_V = OBST_CNT_W'(CAPACITY);

  seq_state_t             state_r, state_nxt;
  obst_in_t               req_r, req_nxt;
  logic [OBST_CNT_W-1:0]  count_r, count_nxt;
  logic [OBST_CNT_W-1:0]  idx_r, idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [OBST_ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                   present_r, present_nxt;
  status_t                status_r, status_nxt;
  logic [OBST_DATA_W-1:0] rval_r, rval_nxt;
  logic                   out_valid_r, out_valid_nxt;
  obst_out_t              out_item_r, out_item_nxt;

  logic in_acc;
  logic issue;
  logic match;
  logic out_free;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (idx_r < count_r);
  assign match    = cmp_vld_r && (rd_data == req_r.element);
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (match || !issue) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (req_r.req_type)
          REQ_DEL:  state_nxt = present_r ? S_SHIFT : S_FINISH;
          REQ_READ: state_nxt = ({1'b0, req_r.position} < count_r) ? S_RWAIT : S_FINISH;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_SHIFT: begin
        if (!issue) state_nxt = S_FINISH;
      end
      S_RWAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    present_nxt   = present_r;
    status_nxt    = status_r;
    rval_nxt      = rval_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_req       = '0;

    unique case (state_r)
      // Latch item, start the scan at entry zero
      S_IDLE: begin
        if (in_acc) begin
          req_nxt     = in_item;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          rval_nxt    = '0;
          status_nxt  = STAT_DONE;
        end
      end
      // Scan: issue one read a cycle, compare the previous read
      S_SEARCH: begin
        if (match) begin
          present_nxt = 1'b1;
          idx_nxt     = {1'b0, cmp_idx_r} + OBST_CNT_W'(1);
          cmp_vld_nxt = 1'b0;
        end else if (!issue) begin
          present_nxt = 1'b0;
          cmp_vld_nxt = 1'b0;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[OBST_ADDR_W-1:0];
          idx_nxt         = idx_r + OBST_CNT_W'(1);
          cmp_vld_nxt     = 1'b1;
          cmp_idx_nxt     = idx_r[OBST_ADDR_W-1:0];
        end
      end
      // Decide the request
      S_EXEC: begin
        unique case (req_r.req_type)
          REQ_ADD: begin
            if (present_r) begin
              status_nxt = STAT_MISS;
            end else if (count_r >= CAP_V) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = count_r[OBST_ADDR_W-1:0];
              mem_req.wr_data = req_r.element;
              count_nxt       = count_r + OBST_CNT_W'(1);
            end
          end
          REQ_DEL: begin
            if (!present_r) status_nxt = STAT_MISS;
          end
          REQ_READ: begin
            if ({1'b0, req_r.position} < count_r) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = req_r.position;
            end else begin
              status_nxt = STAT_RANGE;
            end
          end
          default: ;
        endcase
      end
      // Compact: read entry i, write it back at i-1 next cycle
      S_SHIFT: begin
        if (cmp_vld_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cmp_idx_r - OBST_ADDR_W'(1);
          mem_req.wr_data = rd_data;
        end
        if (issue) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[OBST_ADDR_W-1:0];
          idx_nxt         = idx_r + OBST_CNT_W'(1);
          cmp_vld_nxt     = 1'b1;
          cmp_idx_nxt     = idx_r[OBST_ADDR_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
          count_nxt   = count_r - OBST_CNT_W'(1);
        end
      end
      // Capture positional read
      S_RWAIT: begin
        rval_nxt = rd_data;
      end
      // Hand the result to the output register
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = status_r;
          out_item_nxt.entry_count = count_r;
          out_item_nxt.read_value  = rval_r;
          out_item_nxt.was_present = present_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    present_r  <= present_nxt;
    status_r   <= status_nxt;
    rval_r     <= rval_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  // Entry count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V)
    else $error("entry count above capacity");

  // Store reads stay below the entry count
  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |-> ({1'b0, mem_req.rd_addr} < count_r))
    else $error("read of an entry beyond the count");

  // Store writes only while applying an add or compacting
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_EXEC || state_r == S_SHIFT))
    else $error("store write outside add or compact");

  // Count changes only after an add decision or the end of a compaction
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ($past(state_r) == S_EXEC || $past(state_r) == S_SHIFT))
    else $error("entry count changed outside add or delete");
`endif

endmodule

`default_nettype wire

/* hdl/ordered_byte_set_table_core.sv */
// ----------------------------------------------------------------------------
// ordered_byte_set_table_core
// Ordered set of distinct bytes with append, compacting delete and
// positional read.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carries one request: add a byte, delete a
//   byte, or read the entry at a position. out_valid/out_stall/out_item
//   returns one result per request: status, entry count after it, read
//   value and whether the byte was present beforehand.
//   One request is worked at a time; in_stall is high from acceptance until
//   the result is loaded into the output register. The lookup scans the
//   entry memory through one comparator, one entry per cycle; an absent
//   byte scans all entries and one found at position p ends the scan
//   early. A delete then moves the later entries down one place, and a
//   read fetches the entry at its position for the result.
//   A stalled result holds in the output register; the next request can be
//   accepted meanwhile and its result waits until the register frees.
//   Reset empties the table at once (count zero) and holds in_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_byte_set_table_core #(
  parameter int CAPACITY = obst_pkg::OBST_CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire obst_pkg::obst_in_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output obst_pkg::obst_out_t       out_item
);
  import obst_pkg::*;

  mem_req_t               mem_req;
  logic [OBST_DATA_W-1:0] rd_data;

  // Sequencer and comparator
  obst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // Entry memory
  obst_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* bench/tb_ordered_byte_set_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_byte_set_table_core
// Self-checking bench for the ordered byte set table core.
// A directed table covers the empty table, duplicates, misses, reads at the
// position extremes and the unused request code. Random traffic follows,
// mostly valid adds, deletes and reads around a drifting table size, with
// some noise. The run ends with the table filled to its limit and worked
// there. Each result is compared field by field against a behavioral model.
// ----------------------------------------------------------------------------

module tb_ordered_byte_set_table_core;
  import obst_pkg::*;

  localparam int TABLE_CAP    = OBST_CAPACITY;
  localparam int RANDOM_ITEMS = 260;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DIR_ROWS     = 21;

  // One directed row; want is used only when fixed is set
  typedef struct packed {
    req_t      req;
    logic [7:0] elem;
    logic [7:0] pos;
    logic      fixed;
    obst_out_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  obst_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  obst_out_t out_item;

  // Model state of the set
  logic [7:0] set_bytes [0:255];
  int         set_size = 0;
  int         peak_size = 0;

  // Results still owed by the block, oldest first
  obst_out_t  owed_results [$];

  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int calm_left = 0;
  int cycle_count = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty table: read, delete miss
    '{REQ_READ, 8'h00, 8'h00, 1'b1, '{STAT_RANGE, 9'd0, 8'h00, 1'b0}},
    '{REQ_DEL,  8'h00, 8'h00, 1'b1, '{STAT_MISS,  9'd0, 8'h00, 1'b0}},
    // add, duplicate add, top byte
    '{REQ_ADD,  8'h00, 8'hFF, 1'b1, '{STAT_DONE,  9'd1, 8'h00, 1'b0}},
    '{REQ_ADD,  8'h00, 8'h00, 1'b1, '{STAT_MISS,  9'd1, 8'h00, 1'b1}},
    '{REQ_ADD,  8'hFF, 8'h00, 1'b1, '{STAT_DONE,  9'd2, 8'h00, 1'b0}},
    // reads at both ends and past the count
    '{REQ_READ, 8'hA5, 8'h00, 1'b1, '{STAT_DONE,  9'd2, 8'h00, 1'b0}},
    '{REQ_READ, 8'hFF, 8'h01, 1'b1, '{STAT_DONE,  9'd2, 8'hFF, 1'b1}},
    '{REQ_READ, 8'h00, 8'hFF, 1'b1, '{STAT_RANGE, 9'd2, 8'h00, 1'b1}},
    // unused code still reports presence
    '{REQ_NONE, 8'hFF, 8'h55, 1'b1, '{STAT_DONE,  9'd2, 8'h00, 1'b1}},
    '{REQ_ADD,  8'h80, 8'h00, 1'b0, '0},
    '{REQ_ADD,  8'h01, 8'h7F, 1'b0, '0},
    '{REQ_ADD,  8'h7F, 8'h80, 1'b0, '0},
    // head delete moves everything down
    '{REQ_DEL,  8'h00, 8'h00, 1'b0, '0},
    '{REQ_READ, 8'h33, 8'h00, 1'b0, '0},
    '{REQ_READ, 8'h01, 8'h03, 1'b0, '0},
    // tail delete, then the same byte again
    '{REQ_DEL,  8'h7F, 8'h00, 1'b0, '0},
    '{REQ_DEL,  8'h7F, 8'h00, 1'b0, '0},
    '{REQ_READ, 8'h80, 8'h03, 1'b0, '0},
    '{REQ_DEL,  8'h80, 8'h00, 1'b0, '0},
    '{REQ_NONE, 8'h33, 8'hAA, 1'b0, '0},
    '{REQ_READ, 8'h01, 8'h01, 1'b0, '0}
  };

  ordered_byte_set_table_core #(
    .CAPACITY(TABLE_CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_member(logic [7:0] v);
    for (int i = 0; i < set_size; i++) begin
      if (set_bytes[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Only called while the set has room for another byte
  function automatic logic [7:0] pick_absent();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (is_member(v)) v = v + 8'd1;
    return v;
  endfunction

  // Apply one request to the model set and return the result it gives
  function automatic obst_out_t apply_request(obst_in_t it);
    obst_out_t r;
    int hit;
    hit = -1;
    for (int i = 0; i < set_size; i++) begin
      if (hit < 0 && set_bytes[i] == it.element) hit = i;
    end
    r = '0;
    r.status = STAT_DONE;
    r.was_present = (hit >= 0);
    case (it.req_type)
      REQ_ADD: begin
        if (hit >= 0) begin
          r.status = STAT_MISS;
        end else if (set_size >= TABLE_CAP) begin
          r.status = STAT_FULL;
        end else begin
          set_bytes[set_size] = it.element;
          set_size++;
        end
      end
      REQ_DEL: begin
        if (hit < 0) begin
          r.status = STAT_MISS;
        end else begin
          for (int i = hit; i < set_size - 1; i++) set_bytes[i] = set_bytes[i + 1];
          set_size--;
        end
      end
      REQ_READ: begin
        if (int'(it.position) < set_size) r.read_value = set_bytes[it.position];
        else r.status = STAT_RANGE;
      end
      default: ;
    endcase
    r.entry_count = 9'(set_size);
    if (set_size > peak_size) peak_size = set_size;
    return r;
  endfunction

  // Mostly short gaps, some long, and stretches with none
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic obst_in_t make_item(req_t req, logic [7:0] elem, logic [7:0] pos);
    obst_in_t it;
    it.req_type = req;
    it.element = elem;
    it.position = pos;
    return it;
  endfunction

  // Present one item and wait for it to be taken; entered and left at negedge
  task automatic send_request(obst_in_t it, bit fixed, obst_out_t want);
    int gap;
    obst_out_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(it);
    if (fixed) predicted = want;
    owed_results.push_back(predicted);
    status_tally[predicted.status]++;
    sent_count++;
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed_results.size() != 0);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Compare each taken result with the oldest owed one
  always @(posedge clk) begin
    obst_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with none owed, status", out_item.status, -1);
      end else begin
        want = owed_results.pop_front();
        checked_count++;
        if (out_item.status != want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.entry_count != want.entry_count)
          report_mismatch("entry_count", out_item.entry_count, want.entry_count);
        if (out_item.read_value != want.read_value)
          report_mismatch("read_value", out_item.read_value, want.read_value);
        if (out_item.was_present != want.was_present)
          report_mismatch("was_present", out_item.was_present, want.was_present);
      end
    end
  end

  // Receiver stalls: free stretches, short stalls and a few long ones
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      @(negedge clk);
      if (r < 40) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        if (r < 85) repeat ($urandom_range(0, 2)) @(negedge clk);
        else if (r < 96) repeat ($urandom_range(3, 10)) @(negedge clk);
        else repeat ($urandom_range(15, 40)) @(negedge clk);
      end
    end
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results owed", cycle_count, owed_results.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    obst_in_t it;
    int       taken;
    int       target;
    int       r;
    int       start;
    logic [7:0] v;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      send_request(make_item(dir_rows[k].req, dir_rows[k].elem, dir_rows[k].pos),
                   dir_rows[k].fixed, dir_rows[k].want);
    end
    drain_results();

    // Random traffic around a drifting table size
    taken = 0;
    target = 8;
    while (taken < RANDOM_ITEMS) begin
      if (taken % 75 == 0) begin
        r = $urandom_range(0, 4);
        target = (r == 0) ? 2 : (r == 1) ? 8 : (r == 2) ? 24 : (r == 3) ? 64 : 120;
      end
      if (taken == RANDOM_ITEMS / 2) drain_results();
      it = make_item(REQ_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed request
        r = $urandom_range(0, 99);
        if (set_size == 0 || (r < ((set_size < target) ? 55 : 15) && set_size < TABLE_CAP)) begin
          it.req_type = REQ_ADD;
          it.element = pick_absent();
        end else if (r < 70) begin
          it.req_type = REQ_DEL;
          it.element = set_bytes[$urandom_range(0, set_size - 1)];
        end else begin
          it.req_type = REQ_READ;
          it.position = 8'($urandom_range(0, set_size - 1));
        end
      end else begin
        // noise: duplicate, miss, out-of-range read or unused code
        r = $urandom_range(0, 3);
        if (r == 0 && set_size > 0) begin
          it.req_type = REQ_ADD;
          it.element = set_bytes[$urandom_range(0, set_size - 1)];
        end else if (r == 1 && set_size < 256) begin
          it.req_type = REQ_DEL;
          it.element = pick_absent();
        end else if (r == 2) begin
          it.req_type = REQ_READ;
          if (set_size < 256) it.position = 8'($urandom_range(set_size, 255));
        end
      end
      send_request(it, 1'b0, '0);
      if (it.req_type != REQ_NONE) taken++;
    end
    drain_results();

    // Fill the table to its limit, then work it while full
    start = $urandom_range(0, 255);
    for (int i = 0; i < 256; i++) begin
      send_request(make_item(REQ_ADD, 8'(start + i), 8'($urandom_range(0, 255))), 1'b0, '0);
    end
    for (int i = 0; i < 40; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        v = set_bytes[$urandom_range(0, set_size - 1)];
        send_request(make_item(REQ_ADD, v, 8'($urandom_range(0, 255))), 1'b0, '0);
      end else if (r < 50) begin
        v = 8'((r < 35) ? 255 : $urandom_range(0, 255));
        send_request(make_item(REQ_READ, 8'($urandom_range(0, 255)), v), 1'b0, '0);
      end else begin
        v = (r < 75) ? set_bytes[0] : set_bytes[$urandom_range(0, set_size - 1)];
        send_request(make_item(REQ_DEL, v, 8'($urandom_range(0, 255))), 1'b0, '0);
        send_request(make_item(REQ_ADD, pick_absent(), 8'($urandom_range(0, 255))),
                     1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("covered %0d requests, %0d results checked, table size peaked at %0d",
             sent_count, checked_count, peak_size);
    $display("status mix: done %0d, miss %0d, full %0d, out of range %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* ordered_byte_set_table_core.f */
hdl/obst_pkg.sv
hdl/obst_store.sv
hdl/obst_ctrl.sv
hdl/ordered_byte_set_table_core.sv
bench/tb_ordered_byte_set_table_core.sv
